/* src/wsd_pkg.sv */
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by the parser and the top level.
package wsd_pkg;

  // Parser phase codes
  localparam logic [2:0] PH_HDR0 = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_EXT  = 3'd2;
  localparam logic [2:0] PH_KEY  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;

  // Length codes of the second header byte
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  localparam logic [3:0] EXT_BYTES_16 = 4'd2;
  localparam logic [3:0] EXT_BYTES_64 = 4'd8;
  localparam logic [2:0] KEY_BYTES    = 3'd4;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       frame_last;
  } wsd_res_t;

endpackage

/* src/wsd_parse.sv */
// Header parser and unmasking datapath of the WebSocket frame deframer.
// Depends on wsd_pkg; one byte is consumed per take_i cycle.
module wsd_parse (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [7:0]        stream_byte_i,
  output logic              res_valid_o,
  output wsd_pkg::wsd_res_t res_o
);
  import wsd_pkg::*;

  logic [2:0]  phase_q, phase_d;
  logic [3:0]  ext_len_count_q, ext_len_count_d;
  logic [63:0] remaining_len_q, remaining_len_d;
  logic [31:0] mask_key_q, mask_key_d;
  logic [2:0]  key_byte_count_q, key_byte_count_d;
  logic        mask_on_q, mask_on_d;
  logic [1:0]  payload_index_q, payload_index_d;

  logic [6:0]  len_code;
  logic [63:0] len_shift;
  logic [3:0]  ext_dec;
  logic [2:0]  key_inc;
  logic [7:0]  key_sel;

  assign len_code  = stream_byte_i[6:0];
  assign len_shift = {remaining_len_q[55:0], stream_byte_i};
  assign ext_dec   = ext_len_count_q - 4'd1;
  assign key_inc   = key_byte_count_q + 3'd1;

  always_comb begin
    case (payload_index_q)
      2'd0:    key_sel = mask_key_q[31:24];
      2'd1:    key_sel = mask_key_q[23:16];
      2'd2:    key_sel = mask_key_q[15:8];
      default: key_sel = mask_key_q[7:0];
    endcase
    if (!mask_on_q) key_sel = 8'h00;
  end

  always_comb begin
    phase_d          = phase_q;
    ext_len_count_d  = ext_len_count_q;
    remaining_len_d  = remaining_len_q;
    mask_key_d       = mask_key_q;
    key_byte_count_d = key_byte_count_q;
    mask_on_d        = mask_on_q;
    payload_index_d  = payload_index_q;
    res_valid_o      = 1'b0;
    res_o.payload_byte = stream_byte_i ^ key_sel;
    res_o.frame_last   = (remaining_len_q == 64'd1);

    case (phase_q)
      PH_HDR1: begin
        mask_on_d        = stream_byte_i[7];
        mask_key_d       = '0;
        key_byte_count_d = '0;
        payload_index_d  = '0;
        remaining_len_d  = '0;
        if (len_code == LEN_CODE_16) begin
          ext_len_count_d = EXT_BYTES_16;
          phase_d         = PH_EXT;
        end else if (len_code == LEN_CODE_64) begin
          ext_len_count_d = EXT_BYTES_64;
          phase_d         = PH_EXT;
        end else begin
          ext_len_count_d = '0;
          remaining_len_d = {57'd0, len_code};
          if (stream_byte_i[7]) phase_d = PH_KEY;
          else if (len_code != 7'd0) phase_d = PH_DATA;
          else phase_d = PH_HDR0;
        end
      end
      PH_EXT: begin
        remaining_len_d = len_shift;
        ext_len_count_d = ext_dec;
        if (ext_dec == 4'd0) begin
          if (mask_on_q) begin
            key_byte_count_d = '0;
            phase_d          = PH_KEY;
          end else if (len_shift != 64'd0) begin
            phase_d = PH_DATA;
          end else begin
            phase_d = PH_HDR0;
          end
        end
      end
      PH_KEY: begin
        mask_key_d       = {mask_key_q[23:0], stream_byte_i};
        key_byte_count_d = key_inc;
        if (key_inc >= KEY_BYTES) begin
          key_byte_count_d = '0;
          payload_index_d  = '0;
          phase_d = (remaining_len_q != 64'd0) ? PH_DATA : PH_HDR0;
        end
      end
      PH_DATA: begin
        res_valid_o     = take_i;
        remaining_len_d = remaining_len_q - 64'd1;
        payload_index_d = payload_index_q + 2'd1;
        if (remaining_len_q == 64'd1) phase_d = PH_HDR0;
      end
      default: begin
        // first header byte (and unused codes): skip it
        phase_d = PH_HDR1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= PH_HDR0;
      ext_len_count_q  <= '0;
      remaining_len_q  <= '0;
      mask_key_q       <= '0;
      key_byte_count_q <= '0;
      mask_on_q        <= 1'b0;
      payload_index_q  <= '0;
    end else if (take_i) begin
      phase_q          <= phase_d;
      ext_len_count_q  <= ext_len_count_d;
      remaining_len_q  <= remaining_len_d;
      mask_key_q       <= mask_key_d;
      key_byte_count_q <= key_byte_count_d;
      mask_on_q        <= mask_on_d;
      payload_index_q  <= payload_index_d;
    end
  end

endmodule

/* src/websocket_frame_deframer.sv */
// WebSocket frame deframer: takes one stream byte per request and returns unmasked
// payload bytes with a last-of-frame flag. Depends on wsd_pkg and wsd_parse.
//
// A byte is taken in every cycle in which in_valid_i is high and in_stall_o is low;
// the header bytes, the extended length and the mask key update the parser state
// and produce nothing, each payload byte yields one result request. The output
// register is backed by a one-entry skid register, so in_stall_o rises only when
// a result is parked there, after the output side has stalled a full output register.
module websocket_frame_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] stream_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] payload_byte_o,
  output logic       frame_last_o
);
  import wsd_pkg::*;

  logic     take;
  logic     res_valid;
  wsd_res_t res;

  logic     out_valid_q, out_valid_d;
  wsd_res_t out_q, out_d;
  logic     skid_valid_q, skid_valid_d;
  wsd_res_t skid_q, skid_d;
  logic     out_free;

  assign in_stall_o = skid_valid_q;
  assign take       = in_valid_i && !skid_valid_q;

  wsd_parse u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .stream_byte_i (stream_byte_i),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        // drain the parked request first
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = res_valid;
        out_d       = res;
      end
    end else if (res_valid) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o    = out_valid_q;
  assign payload_byte_o = out_q.payload_byte;
  assign frame_last_o   = out_q.frame_last;

endmodule

/* src/wsd_checker.sv */
// Port-level checks for the WebSocket frame deframer, bound to the top level.
// Depends only on the top level's ports.
module wsd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] stream_byte_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] payload_byte_o,
  input logic       frame_last_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(stream_byte_i))
    else $error("stalled request changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(payload_byte_o) && $stable(frame_last_o))
    else $error("stalled result changed");

  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall without output stall");

  a_stall_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && !out_stall_i |=> !in_stall_o)
    else $error("skid register did not drain");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (.*);

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Testbench for websocket_frame_deframer: directed and random frames go in byte by byte, and each
// unmasked payload byte and last flag is checked. Depends on wsd_pkg and the block's RTL.
module testbench;
  import wsd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned RANDOM_BYTES = 400;

  typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_e;

  // Tracks the parser state and holds the payload results still owed by the block.
  class payload_tracker;
    logic [2:0]  phase;
    logic [3:0]  ext_left;
    logic [63:0] bytes_left;
    logic [31:0] key;
    logic [2:0]  key_count;
    logic        masked;
    logic [1:0]  pos;
    wsd_res_t    expected_q[$];
    int          failures;

    function new();
      phase      = PH_HDR0;
      ext_left   = '0;
      bytes_left = '0;
      key        = '0;
      key_count  = '0;
      masked     = 1'b0;
      pos        = '0;
      failures   = 0;
    endfunction

    function void length_done();
      if (masked) begin
        key_count = '0;
        phase     = PH_KEY;
      end else if (bytes_left != 0) begin
        phase = PH_DATA;
      end else begin
        phase = PH_HDR0;
      end
    endfunction

    function void take_stream_byte(logic [7:0] b);
      wsd_res_t   r;
      logic [7:0] k;
      case (phase)
        PH_HDR1: begin
          masked     = b[7];
          key        = '0;
          key_count  = '0;
          pos        = '0;
          bytes_left = '0;
          if (b[6:0] == LEN_CODE_16) begin
            ext_left = EXT_BYTES_16;
            phase    = PH_EXT;
          end else if (b[6:0] == LEN_CODE_64) begin
            ext_left = EXT_BYTES_64;
            phase    = PH_EXT;
          end else begin
            ext_left   = '0;
            bytes_left = 64'(b[6:0]);
            length_done();
          end
        end
        PH_EXT: begin
          bytes_left = {bytes_left[55:0], b};
          ext_left   = ext_left - 4'd1;
          if (ext_left == 0) length_done();
        end
        PH_KEY: begin
          key       = {key[23:0], b};
          key_count = key_count + 3'd1;
          if (key_count >= KEY_BYTES) begin
            key_count = '0;
            pos       = '0;
            phase     = (bytes_left != 0) ? PH_DATA : PH_HDR0;
          end
        end
        PH_DATA: begin
          k = masked ? key[8 * (3 - int'(pos)) +: 8] : 8'h00;
          bytes_left     = bytes_left - 64'd1;
          r.payload_byte = b ^ k;
          r.frame_last   = (bytes_left == 0);
          expected_q     = {expected_q, r};
          pos = pos + 2'd1;
          if (bytes_left == 0) phase = PH_HDR0;
        end
        default: phase = PH_HDR1;
      endcase
    endfunction

    function void check_payload(wsd_res_t got);
      wsd_res_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result payload_byte %02h frame_last %0b",
                 $time, got.payload_byte, got.frame_last);
        failures++;
        return;
      end
      want = expected_q.pop_front();
      if (got.payload_byte !== want.payload_byte) begin
        $display("%0t: payload_byte expected %02h actual %02h",
                 $time, want.payload_byte, got.payload_byte);
        failures++;
      end
      if (got.frame_last !== want.frame_last) begin
        $display("%0t: frame_last expected %0b actual %0b",
                 $time, want.frame_last, got.frame_last);
        failures++;
      end
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] stream_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] payload_byte_o;
  logic       frame_last_o;

  payload_tracker tracker = new();
  int unsigned    cycles;
  int unsigned    sent_bytes;
  int unsigned    rx_hold;
  bit             rx_quiet;

  websocket_frame_deframer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .stream_byte_i  (stream_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .payload_byte_o (payload_byte_o),
    .frame_last_o   (frame_last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: check each accepted result, then stall for a drawn number of cycles.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        tracker.check_payload('{payload_byte: payload_byte_o, frame_last: frame_last_o});
        if ($urandom_range(0, 23) == 0) rx_quiet = !rx_quiet;
        rx_hold = rx_quiet ? 0 : $urandom_range(0, 11);
      end else if (rx_hold > 0) begin
        rx_hold--;
      end
      out_stall_i <= (rx_hold != 0);
    end
  end

  // Hold valid low for the gap, then present the byte until it is taken.
  task automatic send_byte(input logic [7:0] b, input bit burst);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    stream_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.take_stream_byte(b);
    sent_bytes++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.outstanding() != 0) @(posedge clk_i);
  endtask

  // One frame: ignored first byte, length, optional key, then body payload bytes.
  task automatic send_frame(input logic [63:0] len, input int unsigned body,
                            input bit masked, input len_form_e form, input bit burst);
    logic [6:0]  code;
    logic [31:0] mask;
    logic [7:0]  b;
    send_byte(8'($urandom_range(0, 255)), burst);
    case (form)
      LEN_EXT16: code = LEN_CODE_16;
      LEN_EXT64: code = LEN_CODE_64;
      default:   code = len[6:0];
    endcase
    send_byte({masked, code}, burst);
    if (form == LEN_EXT16) begin
      for (int i = 1; i >= 0; i--) send_byte(len[8 * i +: 8], burst);
    end else if (form == LEN_EXT64) begin
      for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8], burst);
    end
    if (masked) begin
      case ($urandom_range(0, 5))
        0:       mask = 32'h0000_0000;
        1:       mask = 32'hffff_ffff;
        default: mask = $urandom;
      endcase
      for (int i = 3; i >= 0; i--) send_byte(mask[8 * i +: 8], burst);
    end
    for (int unsigned i = 0; i < body; i++) begin
      if ($urandom_range(0, 7) == 0) b = {8{1'($urandom_range(0, 1))}};
      else b = 8'($urandom_range(0, 255));
      send_byte(b, burst);
    end
  endtask

  initial begin
    int unsigned len;
    int unsigned frames;
    len_form_e   form;
    bit          burst;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty frames, plain and masked payload, non-minimal lengths.
    send_frame(64'd0, 0, 1'b0, LEN_SHORT, 1'b0);
    send_frame(64'd0, 0, 1'b1, LEN_SHORT, 1'b1);
    send_frame(64'd3, 3, 1'b0, LEN_SHORT, 1'b0);
    send_frame(64'd5, 5, 1'b1, LEN_SHORT, 1'b1);
    send_frame(64'd2, 2, 1'b0, LEN_EXT16, 1'b0);
    send_frame(64'd1, 1, 1'b1, LEN_EXT64, 1'b0);
    send_frame(64'd0, 0, 1'b1, LEN_EXT64, 1'b1);
    send_frame(64'd0, 0, 1'b0, LEN_EXT16, 1'b0);
    wait_drained();

    frames = 0;
    while (sent_bytes < RANDOM_BYTES) begin
      case ($urandom_range(0, 9))
        7, 8:    form = LEN_EXT16;
        9:       form = LEN_EXT64;
        default: form = LEN_SHORT;
      endcase
      case ($urandom_range(0, 19))
        0:       len = 0;
        1:       len = (form == LEN_SHORT) ? 125 : $urandom_range(126, 200);
        default: len = $urandom_range(1, 12);
      endcase
      burst = ($urandom_range(0, 3) == 0);
      send_frame(64'(len), len, $urandom_range(0, 3) != 0, form, burst);
      frames++;
      if (frames % 15 == 0) wait_drained();
    end

    // Length with the top bit set: the frame never completes, so feed only part of it.
    send_frame(64'h8000_0000_0000_0005, 16, 1'b1, LEN_EXT64, 1'b0);

    in_valid_i <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (tracker.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
